// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// Running sample statistics package
// Item types and fixed field widths shared by the front, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int unsigned InSampleW = 16;
  localparam int unsigned OutCountW = 24;
  localparam int unsigned OutMeanW  = 24;
  localparam int unsigned OutSdW    = 24;

  // Internal statistics widths.
  localparam int unsigned SampleBits = 16;
  localparam int unsigned CountBits  = 24;
  localparam int unsigned SumW       = SampleBits + CountBits;
  localparam int unsigned SqW        = 2 * SampleBits + CountBits;
  localparam int unsigned SnapW      = CountBits + 2 * SampleBits + SumW + SqW + 1;

  // Operation codes of an input item.
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic signed [InSampleW-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [OutCountW-1:0]         sample_count;
    logic signed [InSampleW-1:0]  minimum;
    logic signed [InSampleW-1:0]  maximum;
    logic signed [OutMeanW-1:0]   mean;
    logic [OutSdW-1:0]            std_dev;
    logic                         full_res;
  } out_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MDIV,
    ST_SDIV,
    ST_SQRT,
    ST_OUT
  } bk_state_e;

endpackage

`default_nettype wire

// File: rtl/running_sample_statistics.sv
// An accepted input item passes into the back end, then through setup, the
// mean divide, the variance divide and the root steps, and finally loads the
// result register.
// The bit-serial back end takes no new item until the last one is through; the
// front queue holds two items, so input stalls only when both are waiting.
// Reset: asynchronous active low; statistics return to their cleared values.
// ----------------------------------------------------------------------------
// Running sample statistics top level
// Joins the front end, snapshot queue and arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics
  import rss_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire in_item_t in_item_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_item_o
);

  logic             snap_valid, snap_ready;
  logic [SnapW-1:0] snap;

  rss_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .snap_valid_o(snap_valid), .snap_ready_i(snap_ready), .snap_o(snap)
  );

  rss_back u_back (
    .clk_i, .rst_ni, .snap_valid_i(snap_valid), .snap_ready_o(snap_ready),
    .snap_i(snap), .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

`default_nettype wire

// File: rtl/rss_front.sv
// ----------------------------------------------------------------------------
// Running sample statistics front end
// Accepts items, updates count, extremes, sum and sum of squares, and passes
// a snapshot of the statistics to the back end through a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front
  import rss_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             snap_valid_o,
  input  wire              snap_ready_i,
  output logic [SnapW-1:0] snap_o
);

  localparam int unsigned QDepth = 2;

  logic [CountBits-1:0]          count_q, count_d;
  logic signed [SampleBits-1:0]  min_q, min_d, max_q, max_d, s;
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic [SqW-1:0]                sumsq_q, sumsq_d;
  logic                          full;
  logic [2*SampleBits-1:0]       sq;

  logic [SnapW-1:0] queue_q [QDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;
  logic             push, pop;

  assign in_ready_o   = (fill_q != 2'(QDepth));
  assign push         = in_valid_i && in_ready_o;
  assign snap_valid_o = (fill_q != 2'd0);
  assign pop          = snap_valid_o && snap_ready_i;
  assign snap_o       = queue_q[rd_ptr_q];

  // Statistics update for one item.
  always_comb begin
    s        = in_item_i.sample[SampleBits-1:0];
    sq       = (2*SampleBits)'($signed(s) * $signed(s));
    full     = 1'b0;
    count_d  = count_q;
    min_d    = min_q;
    max_d    = max_q;
    sum_d    = sum_q;
    sumsq_d  = sumsq_q;
    if (in_item_i.op == OP_CLEAR) begin
      count_d = '0;
      min_d   = {1'b0, {(SampleBits-1){1'b1}}};
      max_d   = {1'b1, {(SampleBits-1){1'b0}}};
      sum_d   = '0;
      sumsq_d = '0;
    end else if (&count_q) begin
      full = 1'b1;
    end else begin
      count_d = count_q + 1'b1;
      if (s < min_q) min_d = s;
      if (s > max_q) max_d = s;
      sum_d   = sum_q + SumW'(s);
      sumsq_d = sumsq_q + SqW'(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      min_q    <= {1'b0, {(SampleBits-1){1'b1}}};
      max_q    <= {1'b1, {(SampleBits-1){1'b0}}};
      sum_q    <= '0;
      sumsq_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        count_q  <= count_d;
        min_q    <= min_d;
        max_q    <= max_d;
        sum_q    <= sum_d;
        sumsq_q  <= sumsq_d;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Snapshot queue storage.
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= {count_d, min_d, max_d, sum_d, sumsq_d, full};
  end

endmodule

`default_nettype wire

// File: rtl/rss_back.sv
// ----------------------------------------------------------------------------
// Running sample statistics back end
// Computes mean and standard deviation of one snapshot with a shared
// bit-serial divider and a bit-serial square root, then holds the result.
// The wide products for the variance build up by shift and add while the
// mean is divided.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back
  import rss_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              snap_valid_i,
  output logic             snap_ready_o,
  input  wire [SnapW-1:0]  snap_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output out_item_t        out_item_o
);

  // Widths: mean quotient, variance dividend (with 16 fraction bits).
  localparam int unsigned MW   = 2 * CountBits;            // n*(n-1)
  localparam int unsigned DW   = SqW + CountBits + 16;     // scaled M2*n
  localparam int unsigned MNW  = SumW + 8;                 // |sum|*256
  localparam int unsigned RW   = DW / 2 + 1;               // root width
  localparam int unsigned CntW = $clog2(DW + 1);
  localparam int unsigned DivW = (DW > MNW) ? DW : MNW;
  localparam int unsigned P1W  = SqW + CountBits;          // n*sumsq
  localparam int unsigned P2W  = 2 * SumW;                 // sum^2

  logic [CountBits-1:0]          n_q;
  logic signed [SampleBits-1:0]  mn_q, mx_q;
  logic signed [SumW-1:0]        sum_q;
  logic [SqW-1:0]                sumsq_q;
  logic                          full_q, neg_q;
  logic [SumW-1:0]               mag_q;

  bk_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;

  // Shared divider: numerator shifts out into remainder, quotient in.
  logic [DivW-1:0] num_q;
  logic [MW:0]     rem_q;
  logic [MW-1:0]   den_q;
  logic [MW:0]     rem_sh, rem_sub;
  logic            take;

  logic [MW-1:0]   m_q;
  logic [P1W-1:0]  p1_q, mc1_q;
  logic [CountBits-1:0] mb1_q;
  logic [P2W-1:0]  p2_q, mc2_q;
  logic [MNW-1:0]  mean_mag_q;

  // Square root: restoring digit recurrence on the variance word.
  logic [DW-1:0]   x_q;
  logic [RW+1:0]   srem_q, srem_sh, strial;
  logic [RW-1:0]   root_q;

  out_item_t res_q;
  logic      res_v_q;

  assign snap_ready_o = (state_q == ST_IDLE);
  assign out_valid_o  = res_v_q;
  assign out_item_o   = res_q;

  assign rem_sh  = {rem_q[MW-1:0], num_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = !rem_sub[MW];

  assign srem_sh = {srem_q[RW-1:0], x_q[DW-1:DW-2]};
  assign strial  = srem_sh - {root_q, 2'b01};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (snap_valid_i) state_d = ST_MUL;
      ST_MUL:  if (cnt_q == CntW'(1)) state_d = ST_MDIV;
      ST_MDIV: if (cnt_q == '0) state_d = ST_SDIV;
      ST_SDIV: if (cnt_q == '0) state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == '0) state_d = ST_OUT;
      ST_OUT:  if (!res_v_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      res_v_q <= (state_q == ST_OUT && state_d == ST_IDLE) ? 1'b1
                                                           : (res_v_q && !out_ready_i);
      case (state_q)
        ST_IDLE: cnt_q <= CntW'(2);
        ST_MUL:  cnt_q <= (cnt_q == CntW'(1)) ? CntW'(MNW - 1) : cnt_q - 1'b1;
        ST_MDIV: cnt_q <= (cnt_q == '0) ? CntW'(DW - 1) : cnt_q - 1'b1;
        ST_SDIV: cnt_q <= (cnt_q == '0) ? CntW'(DW / 2 - 1) : cnt_q - 1'b1;
        ST_SQRT: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Datapath: one step of the active unit each cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        {n_q, mn_q, mx_q, sum_q, sumsq_q, full_q} <= snap_i;
      end
      ST_MUL: begin
        if (cnt_q == CntW'(2)) begin
          neg_q <= sum_q[SumW-1];
          mag_q <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
          m_q   <= MW'(n_q) * MW'(n_q - 1'b1);
        end else begin
          p1_q  <= '0;
          p2_q  <= '0;
          mc1_q <= P1W'(sumsq_q);
          mb1_q <= n_q;
          mc2_q <= P2W'(mag_q);
          num_q <= DivW'({mag_q, 8'd0}) << (DivW - MNW);
          rem_q <= '0;
          den_q <= MW'(n_q);
        end
      end
      ST_MDIV: begin
        // Mean quotient bits, with the two variance products alongside.
        mean_mag_q <= {mean_mag_q[MNW-2:0], take};
        if (mb1_q[0]) p1_q <= p1_q + mc1_q;
        if (mag_q[0]) p2_q <= p2_q + mc2_q;
        mc1_q <= mc1_q << 1;
        mb1_q <= mb1_q >> 1;
        mc2_q <= mc2_q << 1;
        mag_q <= mag_q >> 1;
        if (cnt_q == '0) begin
          num_q <= DivW'(DW'(p1_q - P1W'(p2_q)) << 16) << (DivW - DW);
          rem_q <= '0;
          den_q <= m_q;
        end else begin
          rem_q <= take ? rem_sub : rem_sh;
          num_q <= num_q << 1;
        end
      end
      ST_SDIV: begin
        // Quotient bits collect in x_q; low 16 dividend bits are zero.
        rem_q <= take ? rem_sub : rem_sh;
        num_q <= num_q << 1;
        x_q   <= {x_q[DW-2:0], take};
        if (cnt_q == '0) begin
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        x_q <= x_q << 2;
        if (!strial[RW+1]) begin
          srem_q <= strial;
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[RW-2:0], 1'b0};
        end
      end
      ST_OUT: begin
        if (!res_v_q || out_ready_i) begin
          res_q.sample_count <= n_q;
          res_q.minimum  <= mn_q;
          res_q.maximum  <= mx_q;
          res_q.full_res <= full_q;
          if (n_q == '0) res_q.mean <= '0;
          else if (mean_mag_q > MNW'(neg_q ? 24'h800000 : 24'h7FFFFF))
            res_q.mean <= neg_q ? 24'h800000 : 24'h7FFFFF;
          else res_q.mean <= neg_q ? OutMeanW'(-mean_mag_q) : OutMeanW'(mean_mag_q);
          if (n_q < CountBits'(2)) res_q.std_dev <= '0;
          else if ((root_q >> OutSdW) != 0) res_q.std_dev <= '1;
          else res_q.std_dev <= OutSdW'(root_q);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// Running sample statistics checker
// Port-level properties of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker
  import rss_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input wire out_item_t out_item_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // With no samples the mean and deviation are zero.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.sample_count == '0 |->
    out_item_o.mean == '0 && out_item_o.std_dev == '0)
    else $error("nonzero statistics with no samples");

  // A single sample has zero deviation and min equal to max.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.sample_count == 24'd1 |->
    out_item_o.std_dev == '0 && out_item_o.minimum == out_item_o.maximum)
    else $error("bad single-sample statistics");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_item_o
);

`default_nettype wire
